[src/tpbb_pkg.sv]
`timescale 1ns / 1ps

package tpbb_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COORD_W     = 8;
    localparam int MEM_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int DIM_W       = 9;
    localparam int RADIUS_W    = 5;
    localparam int ACC_W       = 14;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = ACC_W + RECIP_W;
    localparam int POS_W       = 11;
    localparam logic [1:0] LAST_PASS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INIT,
        ST_PRIME,
        ST_SUM_ADD,
        ST_SUM_SUB
    } t_state;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_BLUR  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_index;

    // ceil(2^20 / (2r+1)), exact floor division for sums below 2^14
    // radius zero behaves as radius one
    localparam logic [RECIP_W-1:0] RECIP [32] = '{
        19'((1048576 +  2) /  3), 19'((1048576 +  2) /  3),
        19'((1048576 +  4) /  5), 19'((1048576 +  6) /  7),
        19'((1048576 +  8) /  9), 19'((1048576 + 10) / 11),
        19'((1048576 + 12) / 13), 19'((1048576 + 14) / 15),
        19'((1048576 + 16) / 17), 19'((1048576 + 18) / 19),
        19'((1048576 + 20) / 21), 19'((1048576 + 22) / 23),
        19'((1048576 + 24) / 25), 19'((1048576 + 26) / 27),
        19'((1048576 + 28) / 29), 19'((1048576 + 30) / 31),
        19'((1048576 + 32) / 33), 19'((1048576 + 34) / 35),
        19'((1048576 + 36) / 37), 19'((1048576 + 38) / 39),
        19'((1048576 + 40) / 41), 19'((1048576 + 42) / 43),
        19'((1048576 + 44) / 45), 19'((1048576 + 46) / 47),
        19'((1048576 + 48) / 49), 19'((1048576 + 50) / 51),
        19'((1048576 + 52) / 53), 19'((1048576 + 54) / 55),
        19'((1048576 + 56) / 57), 19'((1048576 + 58) / 59),
        19'((1048576 + 60) / 61), 19'((1048576 + 62) / 63)
    };

    // clamp a signed position into 0..n-1
    function automatic logic [COORD_W-1:0] clamp_pos(input logic signed [POS_W-1:0] v,
                                                     input logic [DIM_W-1:0] n);
        logic signed [POS_W-1:0] n_s;
        logic [DIM_W-1:0]        n_m1;
        n_s  = $signed({{(POS_W-DIM_W){1'b0}}, n});
        n_m1 = n - 9'd1;
        if (v < 0) begin
            clamp_pos = '0;
        end else if (v >= n_s) begin
            clamp_pos = n_m1[COORD_W-1:0];
        end else begin
            clamp_pos = v[COORD_W-1:0];
        end
    endfunction

    // saturate a dimension register into 1..hi
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
        if (v == '0) begin
            sat_dim = 9'd1;
        end else if (v > hi) begin
            sat_dim = hi;
        end else begin
            sat_dim = v;
        end
    endfunction

endpackage

[src/three_pass_box_blur.sv]
// Three-pass separable box blur over a 256x256 8-bit alpha image kept in an on-chip
// store. A write pixel transaction and an unused action are answered from idle; a read
// pixel transaction goes through a read state (the store read is registered). A blur transaction runs
// three passes, each a horizontal box filter into a scratch store and a vertical one
// back into the image store. With r the effective radius, its length is set by the
// single read port of each store: a line primes its running sum with 2r+1 reads,
// then each pixel needs one add read and one subtract read, while the shared
// reciprocal multiplier does the division by the window size. The input is not
// ready while a transaction is in progress.
`timescale 1ns / 1ps

module three_pass_box_blur (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // column [7:0], row [15:8], alpha_in [23:16]
    input  logic [1:0]  i_s_axis_tuser,   // action [1:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // alpha_out [7:0], done_res [8], zeros [15:9]
);
    import tpbb_pkg::*;

    t_state                 r_state;
    t_state                 n_state;

    logic [DIM_W-1:0]       r_img_w;
    logic [DIM_W-1:0]       r_img_h;
    logic [RADIUS_W-1:0]    r_radius;

    logic                   r_out_vld;
    logic [7:0]             r_out_alpha;
    logic                   r_out_done;

    logic [1:0]             r_pass;
    logic                   r_vert;
    logic [COORD_W-1:0]     r_line;
    logic [COORD_W-1:0]     r_pos;
    logic [5:0]             r_cnt;
    logic [ACC_W-1:0]       r_acc;
    logic [PROD_W-1:0]      r_prod;

    logic [7:0]             r_img_mem  [MEM_DEPTH];
    logic [7:0]             r_pass_mem [MEM_DEPTH];
    logic [7:0]             r_img_rd;
    logic [7:0]             r_pass_rd;

    logic                   cfg_we;
    logic                   s_fire;
    t_action                act;
    logic [COORD_W-1:0]     in_col;
    logic [COORD_W-1:0]     in_row;
    logic [7:0]             in_alpha;

    logic [DIM_W-1:0]       w_eff;
    logic [DIM_W-1:0]       h_eff;
    logic [RADIUS_W-1:0]    r_eff;
    logic [DIM_W-1:0]       line_len;
    logic [DIM_W-1:0]       line_cnt;
    logic [DIM_W-1:0]       len_m1;
    logic [DIM_W-1:0]       cnt_m1;
    logic                   last_pos;
    logic                   last_line;
    logic                   init_end;
    logic [7:0]             src_rd;

    logic signed [POS_W-1:0] rd_idx;
    logic [COORD_W-1:0]     rd_pos;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      img_raddr;
    logic [ADDR_W-1:0]      img_waddr;
    logic [7:0]             img_wdata;
    logic                   img_we;
    logic                   pass_we;
    logic [7:0]             blur_q;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb begin
        case (t_reg_index'(paddr[3:2]))
            REG_WIDTH:  prdata = {23'd0, r_img_w};
            REG_HEIGHT: prdata = {23'd0, r_img_h};
            REG_RADIUS: prdata = {27'd0, r_radius};
            default:    prdata = '0;
        endcase
    end

    // stream fields
    assign act      = t_action'(i_s_axis_tuser);
    assign in_col   = i_s_axis_tdata[7:0];
    assign in_row   = i_s_axis_tdata[15:8];
    assign in_alpha = i_s_axis_tdata[23:16];

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign s_fire          = i_s_axis_tvalid & o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out_done, r_out_alpha};

    // effective geometry
    assign w_eff     = sat_dim(r_img_w, DIM_W'(MAX_WIDTH));
    assign h_eff     = sat_dim(r_img_h, DIM_W'(MAX_HEIGHT));
    assign r_eff     = (r_radius == '0) ? RADIUS_W'(1) : r_radius;
    assign line_len  = r_vert ? h_eff : w_eff;
    assign line_cnt  = r_vert ? w_eff : h_eff;
    assign len_m1    = line_len - 9'd1;
    assign cnt_m1    = line_cnt - 9'd1;
    assign last_pos  = (r_pos == len_m1[COORD_W-1:0]);
    assign last_line = (r_line == cnt_m1[COORD_W-1:0]);
    assign init_end  = (r_cnt == {r_eff, 1'b0});
    assign src_rd    = r_vert ? r_pass_rd : r_img_rd;
    assign blur_q    = r_prod[RECIP_SHIFT +: 8];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    case (act)
                        ACT_BLUR: n_state = ST_INIT;
                        ACT_READ: n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:    n_state = ST_IDLE;
            ST_INIT: begin
                if (init_end) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME:   n_state = ST_SUM_ADD;
            ST_SUM_ADD: n_state = ST_SUM_SUB;
            ST_SUM_SUB: begin
                if (!last_pos) begin
                    n_state = ST_SUM_ADD;
                end else if (last_line && r_vert && (r_pass == LAST_PASS)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_INIT;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // store addressing and write enables
    always_comb begin
        case (r_state)
            ST_INIT:    rd_idx = $signed({5'd0, r_cnt}) - $signed({6'd0, r_eff});
            ST_PRIME:   rd_idx = $signed({6'd0, r_eff}) + 11'sd1;
            ST_SUM_ADD: rd_idx = $signed({3'd0, r_pos}) - $signed({6'd0, r_eff});
            ST_SUM_SUB: rd_idx = $signed({3'd0, r_pos}) + $signed({6'd0, r_eff}) + 11'sd2;
            default:    rd_idx = '0;
        endcase
        rd_pos  = clamp_pos(rd_idx, line_len);
        rd_addr = r_vert ? {rd_pos, r_line} : {r_line, rd_pos};
        wr_addr = r_vert ? {r_pos, r_line} : {r_line, r_pos};

        img_raddr = (r_state == ST_IDLE) ? {in_row, in_col} : rd_addr;

        pass_we = (r_state == ST_SUM_SUB) && !r_vert;
        if ((r_state == ST_IDLE) && s_fire && (act == ACT_WRITE)) begin
            img_we    = 1'b1;
            img_waddr = {in_row, in_col};
            img_wdata = in_alpha;
        end else begin
            img_we    = (r_state == ST_SUM_SUB) && r_vert;
            img_waddr = wr_addr;
            img_wdata = blur_q;
        end
    end

    // image and scratch stores
    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_img_mem[img_waddr] <= img_wdata;
        end
        r_img_rd <= r_img_mem[img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pass_we) begin
            r_pass_mem[wr_addr] <= blur_q;
        end
        r_pass_rd <= r_pass_mem[rd_addr];
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_img_w   <= 9'd256;
            r_img_h   <= 9'd256;
            r_radius  <= 5'd3;
            r_out_vld <= 1'b0;
            r_pass    <= '0;
            r_vert    <= 1'b0;
            r_line    <= '0;
            r_pos     <= '0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;

            if (cfg_we) begin
                case (t_reg_index'(paddr[3:2]))
                    REG_WIDTH:  r_img_w  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT: r_img_h  <= pwdata[DIM_W-1:0];
                    REG_RADIUS: r_radius <= pwdata[RADIUS_W-1:0];
                    default:    ;
                endcase
            end

            if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (act)
                            ACT_WRITE: begin
                                r_out_vld   <= 1'b1;
                                r_out_alpha <= '0;
                                r_out_done  <= 1'b1;
                            end
                            ACT_BLUR: begin
                                r_pass <= '0;
                                r_vert <= 1'b0;
                                r_line <= '0;
                                r_pos  <= '0;
                                r_cnt  <= '0;
                            end
                            ACT_READ: ;
                            default: begin
                                r_out_vld   <= 1'b1;
                                r_out_alpha <= '0;
                                r_out_done  <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_out_vld   <= 1'b1;
                    r_out_alpha <= r_img_rd;
                    r_out_done  <= 1'b1;
                end
                ST_INIT: begin
                    // read data arrives in the cycle after its address is presented
                    r_acc <= (r_cnt == '0) ? '0 : r_acc + ACC_W'(src_rd);
                    r_cnt <= r_cnt + 6'd1;
                    r_pos <= '0;
                end
                ST_PRIME: begin
                    r_acc <= r_acc + ACC_W'(src_rd);
                end
                ST_SUM_ADD: begin
                    r_prod <= PROD_W'(r_acc) * PROD_W'(RECIP[r_eff]);
                    r_acc  <= r_acc + ACC_W'(src_rd);
                end
                ST_SUM_SUB: begin
                    r_acc <= r_acc - ACC_W'(src_rd);
                    r_pos <= r_pos + 8'd1;
                    r_cnt <= '0;
                    if (last_pos) begin
                        if (last_line) begin
                            r_line <= '0;
                            if (r_vert) begin
                                r_vert <= 1'b0;
                                if (r_pass == LAST_PASS) begin
                                    r_out_vld   <= 1'b1;
                                    r_out_alpha <= '0;
                                    r_out_done  <= 1'b1;
                                end else begin
                                    r_pass <= r_pass + 2'd1;
                                end
                            end else begin
                                r_vert <= 1'b1;
                            end
                        end else begin
                            r_line <= r_line + 8'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
